[rtl/rrts_pkg.sv]
// rrts_pkg: shared constants and types of the round-robin thread scheduler
// request, status and thread mode codes, port widths, parameter defaults
// no dependencies
package rrts_pkg;

  localparam int ThreadsDef   = 16;
  localparam int CountBitsDef = 32;

  localparam int ReqW    = 3;
  localparam int TidW    = 4;
  localparam int StatusW = 3;
  localparam int OutCntW = 32;

  typedef logic [ReqW-1:0]    req_t;
  typedef logic [StatusW-1:0] status_t;
  typedef logic [1:0]         mode_t;

  localparam req_t REQ_TICK   = 3'd0;
  localparam req_t REQ_SPAWN  = 3'd1;
  localparam req_t REQ_TERM   = 3'd2;
  localparam req_t REQ_BLOCK  = 3'd3;
  localparam req_t REQ_RESUME = 3'd4;
  localparam req_t REQ_QUERY  = 3'd5;

  localparam status_t ST_OK      = 3'd0;
  localparam status_t ST_INVALID = 3'd1;
  localparam status_t ST_FULL    = 3'd2;
  localparam status_t ST_MAIN    = 3'd3;
  localparam status_t ST_HALT    = 3'd4;

  localparam mode_t MODE_RUN     = 2'd0;
  localparam mode_t MODE_BLOCKED = 2'd1;
  localparam mode_t MODE_READY   = 2'd2;

endpackage

[rtl/round_robin_thread_scheduler_unit.sv]
// Round-robin thread scheduler: one request at a time; the result word is registered
// in the done state and the next request is taken only after that, once the output is
// not stalled. The longest requests are block/terminate of a queued thread, which walk
// the ready queue through the queue ram (a read and a write state per entry).
// Synchronous active-low reset: thread 0 running with one quantum, queue empty;
// queue ram contents are not cleared. Uses rrts_pkg, rrts_ram, rrts_alu.
module round_robin_thread_scheduler_unit #(
  parameter int THREADS    = rrts_pkg::ThreadsDef,
  parameter int COUNT_BITS = rrts_pkg::CountBitsDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [rrts_pkg::ReqW-1:0]    in_req_type,
  input  logic [rrts_pkg::TidW-1:0]    in_thread_id,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [rrts_pkg::StatusW-1:0] out_status,
  output logic [rrts_pkg::TidW-1:0]    out_new_id,
  output logic [rrts_pkg::TidW-1:0]    out_running_id,
  output logic [rrts_pkg::OutCntW-1:0] out_thread_quantums,
  output logic [rrts_pkg::OutCntW-1:0] out_total_quantums
);

  localparam int IdW   = $clog2(THREADS);
  localparam int FillW = IdW + 1;
  localparam int OutW  = rrts_pkg::OutCntW;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECODE  = 4'd1;
  localparam logic [3:0] S_TICK_WR = 4'd2;
  localparam logic [3:0] S_DISP_RD = 4'd3;
  localparam logic [3:0] S_DISP_WR = 4'd4;
  localparam logic [3:0] S_SCAN    = 4'd5;
  localparam logic [3:0] S_WALK_RD = 4'd6;
  localparam logic [3:0] S_WALK_WR = 4'd7;
  localparam logic [3:0] S_QUERY   = 4'd8;
  localparam logic [3:0] S_DONE    = 4'd9;

  function automatic logic [OutW-1:0] clip_out(input logic [COUNT_BITS-1:0] v);
    logic [COUNT_BITS-1:0] hi;
    hi = v >> OutW;
    return (hi != '0) ? '1 : OutW'(v);
  endfunction

  logic [3:0]                  state_r, state_nxt;
  rrts_pkg::req_t              req_r, req_nxt;
  logic [rrts_pkg::TidW-1:0]   tid_r, tid_nxt;
  logic [IdW-1:0]              head_r, head_nxt;
  logic [FillW-1:0]            fill_r, fill_nxt;
  logic [IdW-1:0]              cur_r, cur_nxt;
  logic [COUNT_BITS-1:0]       elapsed_r, elapsed_nxt;
  logic [THREADS-1:0]          slot_used_r, slot_used_nxt;
  logic [THREADS-1:0]          cnt_vld_r, cnt_vld_nxt;
  rrts_pkg::mode_t             mode_r [THREADS];
  rrts_pkg::mode_t             mode_nxt [THREADS];
  logic [FillW-1:0]            i_r, i_nxt;
  logic [FillW-1:0]            n_r, n_nxt;
  rrts_pkg::status_t           status_r, status_nxt;
  logic [IdW-1:0]              new_id_r, new_id_nxt;
  logic [OutW-1:0]             tq_r, tq_nxt;
  logic                        q_vld_r, q_one_r;
  logic                        out_valid_r, out_valid_nxt;
  rrts_pkg::status_t           out_status_r, out_status_nxt;
  logic [rrts_pkg::TidW-1:0]   out_new_id_r, out_new_id_nxt;
  logic [rrts_pkg::TidW-1:0]   out_running_r, out_running_nxt;
  logic [OutW-1:0]             out_tq_r, out_tq_nxt;
  logic [OutW-1:0]             out_total_r, out_total_nxt;

  logic [IdW-1:0]        t;
  logic                  tid_ok;
  logic [IdW-1:0]        k;
  logic                  f_we;
  logic [IdW-1:0]        f_waddr, f_raddr, f_wdata, f_rdata;
  logic                  q_we;
  logic [IdW-1:0]        q_raddr;
  logic [COUNT_BITS-1:0] q_rdata, qv;
  logic [COUNT_BITS-1:0] alu_cnt_in, cnt_bump;
  logic [IdW-1:0]        alu_idx_a, idx_sum;
  logic [FillW-1:0]      alu_idx_b;

  assign t       = IdW'(tid_r);
  assign tid_ok  = (int'(tid_r) < THREADS) && slot_used_r[t];
  assign k       = i_r[IdW-1:0];
  assign q_raddr = (req_r == rrts_pkg::REQ_QUERY) ? t : cur_r;
  assign qv      = q_vld_r ? q_rdata : (q_one_r ? COUNT_BITS'(1) : '0);
  assign f_waddr = idx_sum;
  assign alu_idx_a = head_r;

  rrts_ram #(.WIDTH(IdW), .DEPTH(THREADS)) u_queue_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  rrts_ram #(.WIDTH(COUNT_BITS), .DEPTH(THREADS)) u_quantum_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (cur_r),
    .wdata (cnt_bump),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  rrts_alu #(.THREADS(THREADS), .COUNT_BITS(COUNT_BITS)) u_alu (
    .cnt_in   (alu_cnt_in),
    .cnt_bump (cnt_bump),
    .idx_a    (alu_idx_a),
    .idx_b    (alu_idx_b),
    .idx_sum  (idx_sum)
  );

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    tid_nxt       = tid_r;
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    cur_nxt       = cur_r;
    elapsed_nxt   = elapsed_r;
    slot_used_nxt = slot_used_r;
    cnt_vld_nxt   = cnt_vld_r;
    mode_nxt      = mode_r;
    i_nxt         = i_r;
    n_nxt         = n_r;
    status_nxt    = status_r;
    new_id_nxt    = new_id_r;
    tq_nxt        = tq_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_status_nxt  = out_status_r;
    out_new_id_nxt  = out_new_id_r;
    out_running_nxt = out_running_r;
    out_tq_nxt      = out_tq_r;
    out_total_nxt   = out_total_r;
    f_we       = 1'b0;
    f_wdata    = cur_r;
    f_raddr    = head_r;
    q_we       = 1'b0;
    alu_cnt_in = qv;
    alu_idx_b  = fill_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt    = in_req_type;
          tid_nxt    = in_thread_id;
          status_nxt = rrts_pkg::ST_OK;
          new_id_nxt = '0;
          tq_nxt     = '0;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_DONE;
        case (req_r)
          rrts_pkg::REQ_TICK: begin
            alu_cnt_in      = elapsed_r;
            elapsed_nxt     = cnt_bump;
            mode_nxt[cur_r] = rrts_pkg::MODE_READY;
            state_nxt       = S_TICK_WR;
          end
          rrts_pkg::REQ_SPAWN: begin
            i_nxt     = '0;
            state_nxt = S_SCAN;
          end
          rrts_pkg::REQ_TERM: begin
            if (!tid_ok) begin
              status_nxt = rrts_pkg::ST_INVALID;
            end else if (t == '0) begin
              // main thread gone: back to the reset state
              slot_used_nxt = THREADS'(1);
              cnt_vld_nxt   = '0;
              for (int j = 0; j < THREADS; j++) begin
                mode_nxt[j] = rrts_pkg::MODE_READY;
              end
              mode_nxt[0] = rrts_pkg::MODE_RUN;
              head_nxt    = '0;
              fill_nxt    = '0;
              cur_nxt     = '0;
              elapsed_nxt = COUNT_BITS'(1);
              status_nxt  = rrts_pkg::ST_HALT;
            end else begin
              slot_used_nxt[t] = 1'b0;
              cnt_vld_nxt[t]   = 1'b0;
              mode_nxt[t]      = rrts_pkg::MODE_READY;
              if (mode_r[t] == rrts_pkg::MODE_READY) begin
                i_nxt     = '0;
                n_nxt     = '0;
                state_nxt = S_WALK_RD;
              end else if (mode_r[t] == rrts_pkg::MODE_RUN) begin
                state_nxt = S_DISP_RD;
              end
            end
          end
          rrts_pkg::REQ_BLOCK: begin
            if (!tid_ok) begin
              status_nxt = rrts_pkg::ST_INVALID;
            end else if (t == '0) begin
              status_nxt = rrts_pkg::ST_MAIN;
            end else if (mode_r[t] == rrts_pkg::MODE_READY) begin
              mode_nxt[t] = rrts_pkg::MODE_BLOCKED;
              i_nxt       = '0;
              n_nxt       = '0;
              state_nxt   = S_WALK_RD;
            end else if (mode_r[t] == rrts_pkg::MODE_RUN) begin
              mode_nxt[t] = rrts_pkg::MODE_BLOCKED;
              state_nxt   = S_DISP_RD;
            end
          end
          rrts_pkg::REQ_RESUME: begin
            if (!tid_ok) begin
              status_nxt = rrts_pkg::ST_INVALID;
            end else if (mode_r[t] == rrts_pkg::MODE_BLOCKED) begin
              mode_nxt[t] = rrts_pkg::MODE_READY;
              if (fill_r < FillW'(THREADS)) begin
                f_we     = 1'b1;
                f_wdata  = t;
                fill_nxt = fill_r + FillW'(1);
              end
            end
          end
          rrts_pkg::REQ_QUERY: begin
            if (!tid_ok) begin
              status_nxt = rrts_pkg::ST_INVALID;
            end else begin
              state_nxt = S_QUERY;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_TICK_WR: begin
        q_we               = 1'b1;
        cnt_vld_nxt[cur_r] = 1'b1;
        if (fill_r < FillW'(THREADS)) begin
          f_we     = 1'b1;
          f_wdata  = cur_r;
          fill_nxt = fill_r + FillW'(1);
        end
        state_nxt = S_DISP_RD;
      end
      S_DISP_RD: begin
        if (fill_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          alu_idx_b = FillW'(1);
          head_nxt  = idx_sum;
          fill_nxt  = fill_r - FillW'(1);
          state_nxt = S_DISP_WR;
        end
      end
      S_DISP_WR: begin
        cur_nxt           = f_rdata;
        mode_nxt[f_rdata] = rrts_pkg::MODE_RUN;
        state_nxt         = S_DONE;
      end
      S_SCAN: begin
        if (!slot_used_r[k]) begin
          slot_used_nxt[k] = 1'b1;
          cnt_vld_nxt[k]   = 1'b0;
          mode_nxt[k]      = rrts_pkg::MODE_READY;
          new_id_nxt       = k;
          if (fill_r < FillW'(THREADS)) begin
            f_we     = 1'b1;
            f_wdata  = k;
            fill_nxt = fill_r + FillW'(1);
          end
          state_nxt = S_DONE;
        end else if (i_r == FillW'(THREADS - 1)) begin
          status_nxt = rrts_pkg::ST_FULL;
          state_nxt  = S_DONE;
        end else begin
          i_nxt = i_r + FillW'(1);
        end
      end
      S_WALK_RD: begin
        alu_idx_b = i_r;
        if (i_r < fill_r) begin
          f_raddr   = idx_sum;
          state_nxt = S_WALK_WR;
        end else begin
          fill_nxt  = n_r;
          state_nxt = S_DONE;
        end
      end
      S_WALK_WR: begin
        // compact in place behind the read pointer, head stays
        alu_idx_b = n_r;
        if (f_rdata != t) begin
          f_we    = 1'b1;
          f_wdata = f_rdata;
          n_nxt   = n_r + FillW'(1);
        end
        i_nxt     = i_r + FillW'(1);
        state_nxt = S_WALK_RD;
      end
      S_QUERY: begin
        tq_nxt    = clip_out(qv);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = status_r;
          out_new_id_nxt  = rrts_pkg::TidW'(new_id_r);
          out_running_nxt = rrts_pkg::TidW'(cur_r);
          out_tq_nxt      = tq_r;
          out_total_nxt   = clip_out(elapsed_r);
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      fill_r      <= '0;
      cur_r       <= '0;
      elapsed_r   <= COUNT_BITS'(1);
      slot_used_r <= THREADS'(1);
      cnt_vld_r   <= '0;
      mode_r[0]   <= rrts_pkg::MODE_RUN;
      for (int j = 1; j < THREADS; j++) begin
        mode_r[j] <= rrts_pkg::MODE_READY;
      end
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      cur_r       <= cur_nxt;
      elapsed_r   <= elapsed_nxt;
      slot_used_r <= slot_used_nxt;
      cnt_vld_r   <= cnt_vld_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r         <= req_nxt;
    tid_r         <= tid_nxt;
    i_r           <= i_nxt;
    n_r           <= n_nxt;
    status_r      <= status_nxt;
    new_id_r      <= new_id_nxt;
    tq_r          <= tq_nxt;
    q_vld_r       <= cnt_vld_r[q_raddr];
    q_one_r       <= (q_raddr == '0);
    out_status_r  <= out_status_nxt;
    out_new_id_r  <= out_new_id_nxt;
    out_running_r <= out_running_nxt;
    out_tq_r      <= out_tq_nxt;
    out_total_r   <= out_total_nxt;
  end

  assign in_stall            = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_new_id          = out_new_id_r;
  assign out_running_id      = out_running_r;
  assign out_thread_quantums = out_tq_r;
  assign out_total_quantums  = out_total_r;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FillW'(THREADS))
    else $error("ready queue fill above thread count");

  a_main_used: assert property (@(posedge clk) disable iff (!rst_n)
    slot_used_r[0])
    else $error("main thread slot not in use");

  a_cur_running: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> slot_used_r[cur_r] && mode_r[cur_r] == rrts_pkg::MODE_RUN)
    else $error("current thread not a running used slot");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result word raised outside done state");

  a_walk_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK_RD || state_r == S_WALK_WR) |-> n_r <= i_r)
    else $error("queue compaction write passed read pointer");
`endif

endmodule

[rtl/rrts_ram.sv]
// rrts_ram: generic single-write, single-read ram with registered read data
// no dependencies
module rrts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/rrts_alu.sv]
// rrts_alu: shared arithmetic of the scheduler sequencer
// saturating counter increment and ready-queue index add modulo THREADS
// no dependencies
module rrts_alu #(
  parameter int THREADS    = 16,
  parameter int COUNT_BITS = 32
) (
  input  logic [COUNT_BITS-1:0]      cnt_in,
  output logic [COUNT_BITS-1:0]      cnt_bump,
  input  logic [$clog2(THREADS)-1:0] idx_a,
  input  logic [$clog2(THREADS):0]   idx_b,
  output logic [$clog2(THREADS)-1:0] idx_sum
);

  localparam int IdW  = $clog2(THREADS);
  localparam int SumW = IdW + 2;

  logic [SumW-1:0] raw_sum;
  logic [SumW-1:0] wrap_sum;

  assign cnt_bump = (cnt_in == '1) ? cnt_in : cnt_in + COUNT_BITS'(1);

  assign raw_sum  = SumW'(idx_a) + SumW'(idx_b);
  assign wrap_sum = (raw_sum >= SumW'(THREADS)) ? raw_sum - SumW'(THREADS) : raw_sum;
  assign idx_sum  = IdW'(wrap_sum);

endmodule

[tb/round_robin_thread_scheduler_unit_tb.sv]
`timescale 1ns / 100ps
// round_robin_thread_scheduler_unit_tb: self-checking bench for the thread scheduler
// directed table then weighted random requests, each result word checked against the table or a predictor
// depends on rrts_pkg and round_robin_thread_scheduler_unit
module round_robin_thread_scheduler_unit_tb;

  localparam int THREADS      = rrts_pkg::ThreadsDef;
  localparam int TidW         = rrts_pkg::TidW;
  localparam int OutCntW      = rrts_pkg::OutCntW;
  localparam int RANDOM_ITEMS = 650;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 2 * THREADS + 8;

  localparam rrts_pkg::req_t REQ_UNUSED6 = 3'd6;
  localparam rrts_pkg::req_t REQ_UNUSED7 = 3'd7;

  typedef struct packed {
    rrts_pkg::status_t        status;
    logic [TidW-1:0]          new_id;
    logic [TidW-1:0]          running_id;
    logic [OutCntW-1:0]       thread_quantums;
    logic [OutCntW-1:0]       total_quantums;
  } result_word_t;

  typedef struct {
    rrts_pkg::req_t  req;
    logic [TidW-1:0] tid;
    bit              typed;
    result_word_t    want;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [rrts_pkg::ReqW-1:0] in_req_type = rrts_pkg::REQ_TICK;
  logic [TidW-1:0] in_thread_id = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [rrts_pkg::StatusW-1:0] out_status;
  logic [TidW-1:0] out_new_id;
  logic [TidW-1:0] out_running_id;
  logic [OutCntW-1:0] out_thread_quantums;
  logic [OutCntW-1:0] out_total_quantums;

  // scheduler state as predicted
  bit                 slot_used [THREADS];
  rrts_pkg::mode_t    thread_mode [THREADS];
  logic [OutCntW-1:0] quantum_count [THREADS];
  logic [TidW-1:0]    ready_queue [THREADS];
  int                 queue_head;
  int                 queue_fill;
  logic [TidW-1:0]    active_thread;
  logic [OutCntW-1:0] elapsed_quantums;

  result_word_t  pending_results[$];
  directed_row_t directed_rows[$];
  result_word_t  oldest;
  int send_idle = 14;
  int recv_idle = 71;
  int failures = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int full_answers = 0;
  int halt_answers = 0;
  int cycle_count = 0;

  round_robin_thread_scheduler_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_req_type         (in_req_type),
    .in_thread_id        (in_thread_id),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_new_id          (out_new_id),
    .out_running_id      (out_running_id),
    .out_thread_quantums (out_thread_quantums),
    .out_total_quantums  (out_total_quantums)
  );

  always #5 clk = ~clk;

  function automatic void clear_scheduler();
    for (int i = 0; i < THREADS; i++) begin
      slot_used[i] = 1'b0;
      thread_mode[i] = rrts_pkg::MODE_READY;
      quantum_count[i] = '0;
      ready_queue[i] = '0;
    end
    slot_used[0] = 1'b1;
    thread_mode[0] = rrts_pkg::MODE_RUN;
    quantum_count[0] = OutCntW'(1);
    queue_head = 0;
    queue_fill = 0;
    active_thread = '0;
    elapsed_quantums = OutCntW'(1);
  endfunction

  function automatic logic [OutCntW-1:0] saturating_inc(logic [OutCntW-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic void enqueue_ready(logic [TidW-1:0] id);
    if (queue_fill >= THREADS) return;
    ready_queue[(queue_head + queue_fill) % THREADS] = id;
    queue_fill++;
  endfunction

  function automatic void run_queue_head();
    if (queue_fill == 0) return;
    active_thread = ready_queue[queue_head];
    queue_head = (queue_head + 1) % THREADS;
    queue_fill--;
    thread_mode[active_thread] = rrts_pkg::MODE_RUN;
  endfunction

  function automatic void remove_from_queue(logic [TidW-1:0] id);
    logic [TidW-1:0] kept [THREADS];
    logic [TidW-1:0] entry;
    int n;
    n = 0;
    for (int i = 0; i < queue_fill; i++) begin
      entry = ready_queue[(queue_head + i) % THREADS];
      if (entry != id) begin
        kept[n] = entry;
        n++;
      end
    end
    for (int i = 0; i < n; i++) ready_queue[i] = kept[i];
    queue_head = 0;
    queue_fill = n;
  endfunction

  function automatic result_word_t schedule_request(rrts_pkg::req_t req,
                                                    logic [TidW-1:0] tid);
    result_word_t r;
    bit known;
    int slot;
    r = '0;
    known = slot_used[tid];
    slot = -1;
    case (req)
      rrts_pkg::REQ_TICK: begin
        quantum_count[active_thread] = saturating_inc(quantum_count[active_thread]);
        elapsed_quantums = saturating_inc(elapsed_quantums);
        thread_mode[active_thread] = rrts_pkg::MODE_READY;
        enqueue_ready(active_thread);
        run_queue_head();
      end
      rrts_pkg::REQ_SPAWN: begin
        for (int i = THREADS - 1; i >= 0; i--) if (!slot_used[i]) slot = i;
        if (slot < 0) begin
          r.status = rrts_pkg::ST_FULL;
        end else begin
          slot_used[slot] = 1'b1;
          thread_mode[slot] = rrts_pkg::MODE_READY;
          quantum_count[slot] = '0;
          enqueue_ready(slot[TidW-1:0]);
          r.new_id = slot[TidW-1:0];
        end
      end
      rrts_pkg::REQ_TERM: begin
        if (!known) begin
          r.status = rrts_pkg::ST_INVALID;
        end else if (tid == 0) begin
          clear_scheduler();
          r.status = rrts_pkg::ST_HALT;
        end else begin
          if (thread_mode[tid] == rrts_pkg::MODE_READY) remove_from_queue(tid);
          else if (thread_mode[tid] == rrts_pkg::MODE_RUN) run_queue_head();
          slot_used[tid] = 1'b0;
          thread_mode[tid] = rrts_pkg::MODE_READY;
          quantum_count[tid] = '0;
        end
      end
      rrts_pkg::REQ_BLOCK: begin
        if (!known) begin
          r.status = rrts_pkg::ST_INVALID;
        end else if (tid == 0) begin
          r.status = rrts_pkg::ST_MAIN;
        end else if (thread_mode[tid] == rrts_pkg::MODE_READY) begin
          remove_from_queue(tid);
          thread_mode[tid] = rrts_pkg::MODE_BLOCKED;
        end else if (thread_mode[tid] == rrts_pkg::MODE_RUN) begin
          thread_mode[tid] = rrts_pkg::MODE_BLOCKED;
          run_queue_head();
        end
      end
      rrts_pkg::REQ_RESUME: begin
        if (!known) begin
          r.status = rrts_pkg::ST_INVALID;
        end else if (thread_mode[tid] == rrts_pkg::MODE_BLOCKED) begin
          thread_mode[tid] = rrts_pkg::MODE_READY;
          enqueue_ready(tid);
        end
      end
      rrts_pkg::REQ_QUERY: begin
        if (!known) r.status = rrts_pkg::ST_INVALID;
        else r.thread_quantums = quantum_count[tid];
      end
      default: ;
    endcase
    r.running_id = active_thread;
    r.total_quantums = elapsed_quantums;
    return r;
  endfunction

  function automatic logic [TidW-1:0] pick_target();
    logic [TidW-1:0] live[$];
    if ($urandom_range(0, 4) == 0) return TidW'($urandom_range(0, THREADS - 1));
    for (int i = 0; i < THREADS; i++) if (slot_used[i]) live.push_back(TidW'(i));
    return live[$urandom_range(0, live.size() - 1)];
  endfunction

  task automatic add_row(rrts_pkg::req_t req, logic [TidW-1:0] tid, bit typed,
                         rrts_pkg::status_t st,
                         logic [TidW-1:0] nid, logic [TidW-1:0] run,
                         logic [OutCntW-1:0] tq, logic [OutCntW-1:0] total);
    directed_row_t row;
    row.req = req;
    row.tid = tid;
    row.typed = typed;
    row.want = '{status: st, new_id: nid, running_id: run, thread_quantums: tq,
                 total_quantums: total};
    directed_rows.push_back(row);
  endtask

  task automatic send_request(rrts_pkg::req_t req, logic [TidW-1:0] tid, bit typed,
                              result_word_t fixed);
    result_word_t predicted;
    if ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_thread_id <= tid;
    do @(posedge clk); while (in_stall);
    predicted = schedule_request(req, tid);
    if (typed) predicted = fixed;
    pending_results.push_back(predicted);
    requests_sent++;
    if (predicted.status == rrts_pkg::ST_FULL) full_answers++;
    if (predicted.status == rrts_pkg::ST_HALT) halt_answers++;
  endtask

  task automatic check_field(string name, logic [OutCntW-1:0] want, logic [OutCntW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(0, 99) < recv_idle);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word with no request waiting: status %0d running %0d",
               out_status, out_running_id);
        failures++;
      end else begin
        oldest = pending_results.pop_front();
        check_field("status", OutCntW'(oldest.status), OutCntW'(out_status));
        check_field("new_id", OutCntW'(oldest.new_id), OutCntW'(out_new_id));
        check_field("running_id", OutCntW'(oldest.running_id), OutCntW'(out_running_id));
        check_field("thread_quantums", oldest.thread_quantums, out_thread_quantums);
        check_field("total_quantums", oldest.total_quantums, out_total_quantums);
        results_checked++;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    rrts_pkg::req_t req;
    logic [TidW-1:0] tid;
    int roll;
    clear_scheduler();
    add_row(rrts_pkg::REQ_QUERY,  0,  1, rrts_pkg::ST_OK,      0, 0, 1, 1);
    add_row(rrts_pkg::REQ_QUERY,  15, 1, rrts_pkg::ST_INVALID, 0, 0, 0, 1);
    add_row(rrts_pkg::REQ_BLOCK,  0,  1, rrts_pkg::ST_MAIN,    0, 0, 0, 1);
    add_row(rrts_pkg::REQ_TERM,   9,  1, rrts_pkg::ST_INVALID, 0, 0, 0, 1);
    add_row(rrts_pkg::REQ_RESUME, 0,  1, rrts_pkg::ST_OK,      0, 0, 0, 1);
    add_row(rrts_pkg::REQ_TICK,   0,  1, rrts_pkg::ST_OK,      0, 0, 0, 2);
    add_row(rrts_pkg::REQ_SPAWN,  0,  1, rrts_pkg::ST_OK,      1, 0, 0, 2);
    add_row(rrts_pkg::REQ_SPAWN,  7,  1, rrts_pkg::ST_OK,      2, 0, 0, 2);
    add_row(rrts_pkg::REQ_TICK,   0,  0, rrts_pkg::ST_OK,      0, 0, 0, 0);
    add_row(rrts_pkg::REQ_BLOCK,  1,  0, rrts_pkg::ST_OK,      0, 0, 0, 0);
    add_row(rrts_pkg::REQ_BLOCK,  1,  0, rrts_pkg::ST_OK,      0, 0, 0, 0);
    add_row(rrts_pkg::REQ_RESUME, 1,  0, rrts_pkg::ST_OK,      0, 0, 0, 0);
    add_row(rrts_pkg::REQ_RESUME, 0,  0, rrts_pkg::ST_OK,      0, 0, 0, 0);
    add_row(rrts_pkg::REQ_BLOCK,  2,  0, rrts_pkg::ST_OK,      0, 0, 0, 0);
    add_row(rrts_pkg::REQ_TERM,   1,  0, rrts_pkg::ST_OK,      0, 0, 0, 0);
    add_row(REQ_UNUSED6,          15, 0, rrts_pkg::ST_OK,      0, 0, 0, 0);
    add_row(REQ_UNUSED7,          10, 0, rrts_pkg::ST_OK,      0, 0, 0, 0);
    add_row(rrts_pkg::REQ_SPAWN,  0,  0, rrts_pkg::ST_OK,      0, 0, 0, 0);
    add_row(rrts_pkg::REQ_TICK,   0,  0, rrts_pkg::ST_OK,      0, 0, 0, 0);
    add_row(rrts_pkg::REQ_QUERY,  1,  0, rrts_pkg::ST_OK,      0, 0, 0, 0);
    add_row(rrts_pkg::REQ_QUERY,  0,  0, rrts_pkg::ST_OK,      0, 0, 0, 0);
    add_row(rrts_pkg::REQ_TERM,   0,  1, rrts_pkg::ST_HALT,    0, 0, 0, 1);
    add_row(rrts_pkg::REQ_RESUME, 3,  1, rrts_pkg::ST_INVALID, 0, 0, 0, 1);
    add_row(rrts_pkg::REQ_TICK,   0,  1, rrts_pkg::ST_OK,      0, 0, 0, 2);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].tid, directed_rows[i].typed,
                   directed_rows[i].want);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 220) begin
        send_idle = 71;
        recv_idle = 14;
      end else if (n == 440) begin
        send_idle = 0;
        recv_idle = 0;
      end
      roll = $urandom_range(0, 99);
      tid = pick_target();
      // spawn bursts fill the table
      if ((n % 120) < 25) req = (roll < 70) ? rrts_pkg::REQ_SPAWN : rrts_pkg::REQ_TICK;
      else if (roll < 25) req = rrts_pkg::REQ_TICK;
      else if (roll < 42) req = rrts_pkg::REQ_SPAWN;
      else if (roll < 54) req = rrts_pkg::REQ_TERM;
      else if (roll < 68) req = rrts_pkg::REQ_BLOCK;
      else if (roll < 82) req = rrts_pkg::REQ_RESUME;
      else if (roll < 96) req = rrts_pkg::REQ_QUERY;
      else if (roll < 98) req = REQ_UNUSED6;
      else req = REQ_UNUSED7;
      if (req == rrts_pkg::REQ_TERM && tid == 0 && $urandom_range(0, 3) != 0)
        tid = TidW'($urandom_range(1, THREADS - 1));
      send_request(req, tid, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests sent, %0d result words checked over three stall mixes",
             requests_sent, results_checked);
    $display("%0d spawns refused on a full table, %0d halts through thread zero",
             full_answers, halt_answers);
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
